FILE: rtl/bse_pkg.sv
// Package for the bubble sort engine: sizes, command/status structs, FSM state type.
// No dependencies.
`default_nettype none
package bse_pkg;
    localparam int MAX_ITEMS  = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]             t_count;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic one_left;
    } t_dp_status;
endpackage
`default_nettype wire

FILE: rtl/bse_if.sv
// Valid/ready channel interfaces for the input request and the sorted result.
// Depends on bse_pkg.
`default_nettype none
interface bse_in_if;
    logic                valid;
    logic                ready;
    bse_pkg::t_data      value;
    logic                is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface bse_out_if;
    logic                valid;
    logic                ready;
    bse_pkg::t_data      sorted_value;
    logic                end_of_set;
    logic                overflow;

    modport source (output valid, output sorted_value, output end_of_set,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input end_of_set,
                    input overflow, output ready);
endinterface
`default_nettype wire

FILE: rtl/bse_datapath.sv
// Datapath: row of sorted cells with parallel insertion and shift-out.
// Depends on bse_pkg.
`default_nettype none
module bse_datapath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  bse_pkg::t_dp_cmd    i_cmd,
    input  bse_pkg::t_data      i_din,
    output bse_pkg::t_dp_status o_status,
    output bse_pkg::t_data      o_head
);
    import bse_pkg::*;

    t_data              r_cell [MAX_ITEMS];
    t_data              n_cell [MAX_ITEMS];
    t_count             r_count;
    t_count             n_count;
    logic [MAX_ITEMS-1:0] lt;
    logic               full;

    assign full = (r_count == CNT_W'(MAX_ITEMS));

    // empty cells act as +infinity
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            lt[i] = (CNT_W'(i) >= r_count) || (i_din < r_cell[i]);
        end
    end

    always_comb begin
        n_cell  = r_cell;
        n_count = r_count;
        if (i_cmd.insert && !full) begin
            n_count = r_count + CNT_W'(1);
            if (lt[0]) begin
                n_cell[0] = i_din;
            end
            for (int i = 1; i < MAX_ITEMS; i++) begin
                if (lt[i]) begin
                    n_cell[i] = lt[i-1] ? r_cell[i-1] : i_din;
                end
            end
        end else if (i_cmd.shift) begin
            n_count = r_count - CNT_W'(1);
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                n_cell[i] = r_cell[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_status.full     = full;
    assign o_status.one_left = (r_count == CNT_W'(1));
    assign o_head            = r_cell[0];
endmodule
`default_nettype wire

FILE: rtl/bse_ctrl.sv
// Controller: load/drain state machine and dropped-item flag.
// Depends on bse_pkg.
`default_nettype none
module bse_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_last,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  bse_pkg::t_dp_status i_status,
    output bse_pkg::t_dp_cmd    o_cmd,
    output logic                o_overflow
);
    import bse_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_dropped;
    logic   n_dropped;
    logic   in_take;
    logic   out_take;

    assign in_take  = i_in_valid && (r_state == ST_LOAD);
    assign out_take = i_out_ready && (r_state == ST_DRAIN);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_take && i_in_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_take && i_status.one_left) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_cmd.insert = 1'b0;
        o_cmd.shift  = 1'b0;
        n_dropped    = r_dropped;
        case (r_state)
            ST_LOAD: begin
                o_in_ready   = 1'b1;
                o_cmd.insert = in_take;
                if (in_take && i_status.full) begin
                    n_dropped = 1'b1;
                end
            end
            ST_DRAIN: begin
                o_out_valid = 1'b1;
                o_cmd.shift = out_take;
                if (out_take && i_status.one_left) begin
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_dropped = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

    assign o_overflow = r_dropped;
endmodule
`default_nettype wire

FILE: rtl/bubble_sort_engine.sv
// Top level of the bubble sort engine: controller plus cell-row datapath.
// Depends on bse_pkg, bse_if, bse_ctrl, bse_datapath.
//
//  channel | dir | payload                                 | handshake
//  i_in    | in  | value, is_last                          | valid/ready
//  o_out   | out | sorted_value, end_of_set, overflow      | valid/ready
//
// Load: one request per cycle; each value is inserted into its sorted place
// in the cell row in the cycle it is accepted, unless the row is full (then it is dropped).
// Drain: after the last request, one result per cycle while o_out.ready is
// high, head of the row first; input is not ready until the set is out.
// Reset (synchronous, active low) empties the row and clears the drop flag.
`default_nettype none
module bubble_sort_engine (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bse_in_if.sink     i_in,
    bse_out_if.source  o_out
);
    import bse_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    t_data      head;
    logic       overflow;

    bse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.is_last),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_overflow  (overflow)
    );

    bse_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_din    (i_in.value),
        .o_status (status),
        .o_head   (head)
    );

    assign o_out.sorted_value = head;
    assign o_out.end_of_set   = status.one_left;
    assign o_out.overflow     = overflow;
endmodule
`default_nettype wire
